// ===== sv/ccn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccn_pkg: shared types and constants
// Parse phases, character codes, character classes and the result bundle
// for the compound name canonicaliser.
// ----------------------------------------------------------------------------
package ccn_pkg;

    typedef enum logic [8:0] {
        PH_LEAD        = 9'b000000001,
        PH_START       = 9'b000000010,
        PH_NAME        = 9'b000000100,
        PH_NAME_END    = 9'b000001000,
        PH_INDEX       = 9'b000010000,
        PH_INDEX_WORD  = 9'b000100000,
        PH_INDEX_CLOSE = 9'b001000000,
        PH_INDEX_END   = 9'b010000000,
        PH_SKIP        = 9'b100000000
    } phase_t;

    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    typedef struct packed {
        logic       has_char;
        logic [7:0] out_char;
        logic       finished;
        logic       ill_formed;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return c inside {[8'h41:8'h5a]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return is_upper(c) || (c inside {[8'h61:8'h7a]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_USCORE);
    endfunction

    function automatic logic is_value_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c inside {CH_USCORE, CH_DASH, CH_CARET});
    endfunction

    function automatic logic [7:0] map_char(input logic [7:0] c, input logic lower);
        logic [7:0] m;
        m = c;
        if (lower && is_upper(c))
        begin
            m = c + CASE_GAP;
        end
        else if ((c == CH_DASH) || (c == CH_CARET))
        begin
            m = CH_USCORE;
        end
        return m;
    endfunction

endpackage

// ===== sv/ccn_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccn_step: per-character parse step
// Combinational next phase and result for one character against the
// current parse phase.
// ----------------------------------------------------------------------------
module ccn_step (
    input  ccn_pkg::phase_t  phase,
    input  logic [7:0]       in_char,
    input  logic             last_char,
    output ccn_pkg::phase_t  phase_next,
    output logic             res_valid,
    output ccn_pkg::result_t res
);
    import ccn_pkg::*;

    logic       emit;
    logic       fin;
    logic       bad;
    logic       skip;
    logic [7:0] oc;
    phase_t     ph;

    always_comb
    begin
        emit = 1'b0;
        fin  = 1'b0;
        bad  = 1'b0;
        oc   = 8'h00;
        ph   = phase;
        skip = 1'b0;

        case (phase)
            PH_LEAD, PH_START, PH_NAME_END, PH_INDEX, PH_INDEX_CLOSE,
            PH_INDEX_END: ;
            PH_NAME:
            begin
                if (is_value_char(in_char))
                begin
                    emit = 1'b1;
                    oc   = map_char(in_char, 1'b1);
                end
                else
                begin
                    ph = PH_NAME_END;
                end
            end
            PH_INDEX_WORD:
            begin
                if (is_value_char(in_char))
                begin
                    emit = 1'b1;
                    oc   = map_char(in_char, 1'b0);
                end
                else
                begin
                    ph = PH_INDEX_CLOSE;
                end
            end
            default: skip = 1'b1;
        endcase

        if (!emit && !is_space(in_char))
        begin
            case (ph)
                PH_LEAD, PH_START:
                begin
                    if ((ph == PH_LEAD) && (in_char == CH_DOT))
                    begin
                        emit = 1'b1;
                        oc   = in_char;
                        ph   = PH_START;
                    end
                    else if (is_word_start(in_char))
                    begin
                        emit = 1'b1;
                        oc   = map_char(in_char, 1'b1);
                        ph   = PH_NAME;
                    end
                    else
                    begin
                        fin = 1'b1;
                        bad = 1'b1;
                    end
                end
                PH_NAME_END:
                begin
                    if ((in_char == CH_LBRACK) || (in_char == CH_DOT))
                    begin
                        emit = 1'b1;
                        oc   = in_char;
                        ph   = (in_char == CH_DOT) ? PH_START : PH_INDEX;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                PH_INDEX:
                begin
                    if (is_alpha(in_char) || is_digit(in_char))
                    begin
                        emit = 1'b1;
                        oc   = in_char;
                        ph   = PH_INDEX_WORD;
                    end
                    else if (in_char == CH_DOLLAR)
                    begin
                        emit = 1'b1;
                        oc   = in_char;
                        ph   = PH_INDEX_CLOSE;
                    end
                    else if (in_char == CH_RBRACK)
                    begin
                        emit = 1'b1;
                        oc   = in_char;
                        ph   = PH_INDEX_END;
                    end
                    else
                    begin
                        fin = 1'b1;
                        bad = 1'b1;
                    end
                end
                PH_INDEX_CLOSE:
                begin
                    if (in_char == CH_RBRACK)
                    begin
                        emit = 1'b1;
                        oc   = in_char;
                        ph   = PH_INDEX_END;
                    end
                    else
                    begin
                        fin = 1'b1;
                        bad = 1'b1;
                    end
                end
                PH_INDEX_END:
                begin
                    if (in_char == CH_DOT)
                    begin
                        emit = 1'b1;
                        oc   = in_char;
                        ph   = PH_START;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (!fin && last_char)
        begin
            fin = 1'b1;
            bad = !((ph == PH_NAME) || (ph == PH_NAME_END) || (ph == PH_INDEX_END));
        end

        if (fin)
        begin
            ph = last_char ? PH_LEAD : PH_SKIP;
        end

        // ignore phase: swallow everything up to the end of the string
        if (skip)
        begin
            emit = 1'b0;
            fin  = 1'b0;
            bad  = 1'b0;
            oc   = 8'h00;
            ph   = last_char ? PH_LEAD : PH_SKIP;
        end
    end

    assign phase_next     = ph;
    assign res_valid      = emit || fin;
    assign res.has_char   = emit;
    assign res.out_char   = emit ? oc : 8'h00;
    assign res.finished   = fin;
    assign res.ill_formed = fin && bad;

endmodule

// ===== sv/ccn_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccn_out_reg: result register
// Holds one result for the output channel and reports when it can take
// the next one.
// ----------------------------------------------------------------------------
module ccn_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ccn_pkg::result_t res,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output ccn_pkg::result_t out_res
);
    import ccn_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== sv/compound_name_canonicalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compound_name_canonicalizer: streaming compound name canonicaliser
// Input channel (in_valid/in_ready): one raw character per transfer, with
// last_char marking the final character of a name string.
// Output channel (out_valid/out_ready): at most one result per character:
// has_char/out_char carry the canonical character, finished/ill_formed
// report the end of the name and its syntax. Dropped whitespace and
// characters after the name has ended produce no transfer.
// Path: each character is captured in the input register, and its result
// is then loaded into the result register.
// Throughput: one character per cycle while out_ready does not hold the output,
// set by the phase update between the input register and the result register.
// Stall: while the result register is held by out_ready low, the input
// register holds and in_ready drops once it is full.
// Reset: both registers empty, parser at the start of a new name.
// ----------------------------------------------------------------------------
module compound_name_canonicalizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       has_char,
    output logic [7:0] out_char,
    output logic       finished,
    output logic       ill_formed
);
    import ccn_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     step_phase;
    logic       step_valid;
    result_t    step_res;
    result_t    out_res;
    logic       can_load;
    logic       s1_adv;
    logic       in_xfer;

    assign s1_adv        = s1_valid_reg && can_load;
    assign in_ready      = !s1_valid_reg || can_load;
    assign in_xfer       = in_valid && in_ready;
    assign s1_valid_next = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign phase_next    = s1_adv ? step_phase : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= PH_LEAD;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            phase_reg    <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_char_reg <= in_char;
            s1_last_reg <= last_char;
        end
    end

    ccn_step u_step (
        .phase      (phase_reg),
        .in_char    (s1_char_reg),
        .last_char  (s1_last_reg),
        .phase_next (step_phase),
        .res_valid  (step_valid),
        .res        (step_res)
    );

    ccn_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_adv && step_valid),
        .res       (step_res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign has_char   = out_res.has_char;
    assign out_char   = out_res.out_char;
    assign finished   = out_res.finished;
    assign ill_formed = out_res.ill_formed;

`ifndef NO_ASSERTIONS
    a_bad_needs_fin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!ill_formed || finished))
        else $error("ill_formed without finished");

    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_char || finished))
        else $error("empty result transfer");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_char) |-> (out_char == 8'h00))
        else $error("out_char not zero without has_char");

    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=> (phase_reg == PH_LEAD))
        else $error("parser not restarted after last character");
`endif

endmodule

// ===== test/ccn_name_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccn_name_checker: result predictor and comparator for the name canonicaliser
// Watches both channels of compound_name_canonicalizer. Every input transfer
// runs through a local model of the name parser. Each result it gives is queued
// and compared field by field with the next output transfer.
// ----------------------------------------------------------------------------
module ccn_name_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       last_char,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       has_char,
    input  logic [7:0] out_char,
    input  logic       finished,
    input  logic       ill_formed,
    output int         fail_count,
    output int         outstanding,
    output int         results_seen,
    output int         names_clean,
    output int         names_rejected
);
    import ccn_pkg::*;

    phase_t  name_phase;
    result_t canon_q[$];
    result_t pred_r;
    result_t got_r;
    result_t want_r;
    int      misses;
    int      seen;
    int      n_clean;
    int      n_bad;

    function automatic bit blank_c(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic bit letter_c(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    function automatic bit digit_c(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic bit value_c(input logic [7:0] c);
        return letter_c(c) || digit_c(c) || (c == CH_USCORE) || (c == CH_DASH)
            || (c == CH_CARET);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c, input bit lower);
        if (lower && (c >= 8'h41) && (c <= 8'h5a))
        begin
            return c + 8'h20;
        end
        if ((c == CH_DASH) || (c == CH_CARET))
        begin
            return CH_USCORE;
        end
        return c;
    endfunction

    // Advances the parser by one character; returns 1 when a result is due.
    function automatic bit canon_step(input logic [7:0] c, input logic lst,
                                      output result_t r);
        phase_t     ph;
        bit         emit;
        bit         fin;
        bit         bad;
        logic [7:0] oc;
        ph   = name_phase;
        emit = 1'b0;
        fin  = 1'b0;
        bad  = 1'b0;
        oc   = 8'h00;
        r    = '0;
        if (ph == PH_SKIP)
        begin
            if (lst)
            begin
                name_phase = PH_LEAD;
            end
            return 1'b0;
        end
        if (ph == PH_NAME)
        begin
            if (value_c(c))
            begin
                emit = 1'b1;
                oc   = fold(c, 1'b1);
            end
            else
            begin
                ph = PH_NAME_END;
            end
        end
        else if (ph == PH_INDEX_WORD)
        begin
            if (value_c(c))
            begin
                emit = 1'b1;
                oc   = fold(c, 1'b0);
            end
            else
            begin
                ph = PH_INDEX_CLOSE;
            end
        end
        if (!emit && !blank_c(c))
        begin
            case (ph)
                PH_LEAD, PH_START:
                begin
                    if ((ph == PH_LEAD) && (c == CH_DOT))
                    begin
                        emit = 1'b1;
                        oc   = c;
                        ph   = PH_START;
                    end
                    else if (letter_c(c) || (c == CH_USCORE))
                    begin
                        emit = 1'b1;
                        oc   = fold(c, 1'b1);
                        ph   = PH_NAME;
                    end
                    else
                    begin
                        fin = 1'b1;
                        bad = 1'b1;
                    end
                end
                PH_NAME_END:
                begin
                    if (c == CH_LBRACK)
                    begin
                        emit = 1'b1;
                        oc   = c;
                        ph   = PH_INDEX;
                    end
                    else if (c == CH_DOT)
                    begin
                        emit = 1'b1;
                        oc   = c;
                        ph   = PH_START;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                PH_INDEX:
                begin
                    if (letter_c(c) || digit_c(c))
                    begin
                        emit = 1'b1;
                        oc   = c;
                        ph   = PH_INDEX_WORD;
                    end
                    else if (c == CH_DOLLAR)
                    begin
                        emit = 1'b1;
                        oc   = c;
                        ph   = PH_INDEX_CLOSE;
                    end
                    else if (c == CH_RBRACK)
                    begin
                        emit = 1'b1;
                        oc   = c;
                        ph   = PH_INDEX_END;
                    end
                    else
                    begin
                        fin = 1'b1;
                        bad = 1'b1;
                    end
                end
                PH_INDEX_CLOSE:
                begin
                    if (c == CH_RBRACK)
                    begin
                        emit = 1'b1;
                        oc   = c;
                        ph   = PH_INDEX_END;
                    end
                    else
                    begin
                        fin = 1'b1;
                        bad = 1'b1;
                    end
                end
                default:
                begin
                    if (c == CH_DOT)
                    begin
                        emit = 1'b1;
                        oc   = c;
                        ph   = PH_START;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            endcase
        end
        if (!fin && lst)
        begin
            fin = 1'b1;
            bad = !((ph == PH_NAME) || (ph == PH_NAME_END) || (ph == PH_INDEX_END));
        end
        if (fin)
        begin
            ph = lst ? PH_LEAD : PH_SKIP;
        end
        name_phase   = ph;
        r.has_char   = emit;
        r.out_char   = emit ? oc : 8'h00;
        r.finished   = fin;
        r.ill_formed = fin && bad;
        return emit || fin;
    endfunction

    function automatic void flag_miss(input result_t want, input result_t got,
                                      input bit unexpected);
        misses++;
        if (misses <= 10)
        begin
            if (unexpected)
                $display("%0t: unexpected result has=%0b ch=%02h fin=%0b bad=%0b",
                         $realtime, got.has_char, got.out_char, got.finished,
                         got.ill_formed);
            else
            begin
                $write("%0t: mismatch exp has=%0b ch=%02h fin=%0b bad=%0b, ",
                       $realtime, want.has_char, want.out_char, want.finished,
                       want.ill_formed);
                $display("got has=%0b ch=%02h fin=%0b bad=%0b",
                         got.has_char, got.out_char, got.finished, got.ill_formed);
            end
        end
    endfunction

    initial
    begin
        name_phase = PH_LEAD;
        misses     = 0;
        seen       = 0;
        n_clean    = 0;
        n_bad      = 0;
    end

    // Output side is checked before the input side: a result can never belong
    // to a character taken at the same edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            name_phase = PH_LEAD;
            canon_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_r = {has_char, out_char, finished, ill_formed};
                seen++;
                if (canon_q.size() == 0)
                begin
                    flag_miss(got_r, got_r, 1'b1);
                end
                else
                begin
                    want_r = canon_q.pop_front();
                    if (want_r !== got_r)
                    begin
                        flag_miss(want_r, got_r, 1'b0);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (canon_step(in_char, last_char, pred_r))
                begin
                    canon_q.push_back(pred_r);
                    if (pred_r.finished)
                    begin
                        if (pred_r.ill_formed)
                            n_bad++;
                        else
                            n_clean++;
                    end
                end
            end
        end
        fail_count     <= misses;
        outstanding    <= canon_q.size();
        results_seen   <= seen;
        names_clean    <= n_clean;
        names_rejected <= n_bad;
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for compound_name_canonicalizer
// Feeds short directed names and then randomly built names: mostly well-formed,
// some damaged, some pure noise. Both sides idle at random and the output is
// held off once for a long stretch. Checking is done in ccn_name_checker.
// ----------------------------------------------------------------------------
module tb;
    import ccn_pkg::*;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_char   = 8'h00;
    logic       last_char = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic       has_char;
    logic [7:0] out_char;
    logic       finished;
    logic       ill_formed;

    int fail_count;
    int outstanding;
    int results_seen;
    int names_clean;
    int names_rejected;
    int chars_sent = 0;
    int tx_run     = 0;
    bit tx_steady  = 1'b0;
    int rx_run     = 0;
    bit rx_steady  = 1'b0;
    int rx_hold    = 0;
    bit squeezed   = 1'b0;

    always #1 clk = ~clk;

    compound_name_canonicalizer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_char    (in_char),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .has_char   (has_char),
        .out_char   (out_char),
        .finished   (finished),
        .ill_formed (ill_formed)
    );

    ccn_name_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_char        (in_char),
        .last_char      (last_char),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .has_char       (has_char),
        .out_char       (out_char),
        .finished       (finished),
        .ill_formed     (ill_formed),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .results_seen   (results_seen),
        .names_clean    (names_clean),
        .names_rejected (names_rejected)
    );

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_space();
        if ($urandom_range(0, 5) == 0)
            return CH_SPACE;
        return CH_TAB + 8'($urandom_range(0, 4));
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 1) == 0)
            return CH_UPPER + 8'($urandom_range(0, 25));
        return CH_LOWER + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_start();
        return ($urandom_range(0, 9) == 0) ? CH_USCORE : pick_letter();
    endfunction

    function automatic logic [7:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return pick_letter();
        if (r < 8)
            return CH_ZERO + 8'($urandom_range(0, 9));
        if (r == 8)
            return CH_USCORE;
        return ($urandom_range(0, 1) == 0) ? CH_DASH : CH_CARET;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic lst);
        int g;
        if (tx_run == 0)
        begin
            tx_run    = $urandom_range(20, 150);
            tx_steady = ($urandom_range(0, 3) == 0);
        end
        tx_run--;
        g = tx_steady ? 0 : idle_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_char   <= c;
        last_char <= lst;
        do @(posedge clk); while (!in_ready);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // Receiver: random stalls, quiet stretches, and one long hold-off once
    // traffic is flowing so that the block backs up onto its input.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!squeezed && (results_seen >= 400))
            begin
                squeezed = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_run == 0)
                begin
                    rx_run    = $urandom_range(20, 200);
                    rx_steady = ($urandom_range(0, 3) == 0);
                end
                rx_run--;
                rx_hold = rx_steady ? 0 : idle_gap();
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("[compound_name_canonicalizer] ERROR");
        $finish;
    end

    initial
    begin
        logic [7:0] nm[$];
        int         kind;
        int         keep;
        int         waited;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed names: every mapping and phase, legal stops, syntax errors,
        // ill-formed endings, zero byte and top byte
        send_text(".Ab-^[x-Y^].c[$].D[]");
        send_text("a b");
        send_text("a]zz");
        send_text("q[1][");
        send_text("..a");
        send_text("x[");
        send_text("a.");
        send_text(" \t");
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b1);
        send_char(8'hff, 1'b0);
        send_char(8'h00, 1'b1);

        while (chars_sent < 1100)
        begin
            nm.delete();
            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                repeat ($urandom_range(1, 8)) nm.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    nm.push_back(pick_space());
                if ($urandom_range(0, 2) == 0)
                    nm.push_back(CH_DOT);
                nm.push_back(pick_start());
                repeat ($urandom_range(0, 5)) nm.push_back(pick_value());
                repeat ($urandom_range(0, 3))
                begin
                    if ($urandom_range(0, 4) == 0)
                        nm.push_back(pick_space());
                    if ($urandom_range(0, 1) == 0)
                    begin
                        nm.push_back(CH_DOT);
                        nm.push_back(pick_start());
                        repeat ($urandom_range(0, 4)) nm.push_back(pick_value());
                    end
                    else
                    begin
                        nm.push_back(CH_LBRACK);
                        case ($urandom_range(0, 3))
                            0: ;
                            1: nm.push_back(CH_DOLLAR);
                            default:
                            begin
                                nm.push_back(($urandom_range(0, 2) == 0) ?
                                             CH_ZERO + 8'($urandom_range(0, 9)) :
                                             pick_letter());
                                repeat ($urandom_range(0, 4)) nm.push_back(pick_value());
                            end
                        endcase
                        if ($urandom_range(0, 4) == 0)
                            nm.push_back(pick_space());
                        nm.push_back(CH_RBRACK);
                    end
                end
                // damage about a quarter of them
                if (kind >= 75)
                begin
                    case ($urandom_range(0, 2))
                        0: nm[$urandom_range(0, nm.size() - 1)] = 8'($urandom_range(0, 255));
                        1:
                        begin
                            keep = $urandom_range(1, nm.size());
                            while (nm.size() > keep)
                                void'(nm.pop_back());
                        end
                        default:
                            repeat ($urandom_range(1, 4))
                                nm.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            for (int i = 0; i < nm.size(); i++)
            begin
                send_char(nm[i], i == nm.size() - 1);
            end
        end
        in_valid <= 1'b0;

        waited = 0;
        while ((outstanding != 0) && (waited < 5000))
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        $display("Sent %0d characters; %0d results checked.", chars_sent, results_seen);
        $display("Names ended clean: %0d, rejected as ill-formed: %0d.",
                 names_clean, names_rejected);
        if ((fail_count == 0) && (outstanding == 0))
        begin
            $display("[compound_name_canonicalizer] OK");
        end
        else
        begin
            $display("[compound_name_canonicalizer] ERROR");
        end
        $finish;
    end

endmodule
